@@ design/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// md5_pkg
// types, constants and round tables shared by the md5 digest block
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef enum logic {
    ACT_ABSORB = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data_byte;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadMark  = 8'h80;
  localparam logic [5:0]  LenStart = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } core_state_e;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] i);
    logic [4:0] s;
    unique case (i)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

@@ design/md5_queue.sv @@
// ----------------------------------------------------------------------------
// md5_queue
// short fifo of classified input words between front and core
// ----------------------------------------------------------------------------
module md5_queue import md5_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  md5_in_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output md5_in_t pop_data_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  md5_in_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && !empty_o);
    end
  end

endmodule

@@ design/md5_core.sv @@
// ----------------------------------------------------------------------------
// md5_core
// byte packing, padding, one round a cycle and digest output
// ----------------------------------------------------------------------------
module md5_core import md5_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  md5_in_t  word_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output md5_out_t out_data_o
);

  core_state_e state_q, state_d;
  logic [31:0] blk_q [16];
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  pos_q, rnd_q;
  logic [63:0] len_q, total_q;
  logic        fin_q;
  logic        len_done_q;
  logic [1:0]  oidx_q;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [5:0]  pos_nx;
  logic        blk_done;
  logic [1:0]  stg;
  logic [31:0] mix, sum, rot;
  logic [3:0]  widx;
  logic [4:0]  sh;

  assign pos_nx   = pos_q + 6'd1;
  assign blk_done = wr_en && (pos_nx == 6'd0);
  assign stg      = rnd_q[5:4];

  always_comb begin
    unique case (stg)
      2'd0: begin
        mix = (b_q & c_q) | (~b_q & d_q);
        widx = rnd_q[3:0];
      end
      2'd1: begin
        mix = (b_q & d_q) | (c_q & ~d_q);
        widx = 4'(5 * rnd_q + 1);
      end
      2'd2: begin
        mix = b_q ^ c_q ^ d_q;
        widx = 4'(3 * rnd_q + 5);
      end
      default: begin
        mix = c_q ^ (b_q | ~d_q);
        widx = 4'(7 * rnd_q);
      end
    endcase
    sh  = rot_amount({stg, rnd_q[1:0]});
    sum = a_q + mix + round_const(rnd_q) + blk_q[widx];
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          if (pos_q == 6'd63) state_d = ST_ROUND;
          else if (word_i.action == ACT_FINISH) begin
            state_d = (pos_nx == LenStart) ? ST_LEN : ST_PAD;
          end
        end
      end
      ST_PAD:   if (blk_done) state_d = ST_ROUND;
                else if (pos_nx == LenStart) state_d = ST_LEN;
      ST_LEN:   if (blk_done) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
      ST_FOLD:  state_d = fin_q ? (len_done_q ? ST_EMIT : ST_PAD) : ST_IDLE;
      ST_EMIT:  if (out_ready_i && oidx_q == 2'd3) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o   = 1'b0;
    wr_en   = 1'b0;
    wr_byte = PadMark;
    unique case (state_q)
      ST_IDLE: begin
        pop_o = !empty_i;
        wr_en = !empty_i;
        wr_byte = (word_i.action == ACT_FINISH) ? PadMark : word_i.data_byte;
      end
      ST_PAD: begin
        wr_en = 1'b1;
        wr_byte = 8'h00;
      end
      ST_LEN: begin
        wr_en = 1'b1;
        wr_byte = total_q[{pos_q[2:0], 3'b000} +: 8];
      end
      default: ;
    endcase
  end

  assign out_valid_o            = (state_q == ST_EMIT);
  assign out_data_o.digest_word = h_q[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.last_word   = (oidx_q == 2'd3);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (pos_q[1:0] == 2'd0) blk_q[pos_q[5:2]] <= {24'd0, wr_byte};
      else blk_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (state_q == ST_IDLE && !empty_i && word_i.action == ACT_FINISH) total_q <= len_q;
    if (blk_done) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
    end else if (state_q == ST_ROUND) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_q      <= '0;
      rnd_q      <= '0;
      len_q      <= '0;
      fin_q      <= 1'b0;
      len_done_q <= 1'b0;
      oidx_q     <= '0;
      h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
    end else begin
      state_q <= state_d;
      if (wr_en) pos_q <= pos_nx;
      if (state_q == ST_IDLE && !empty_i) begin
        if (word_i.action == ACT_FINISH) fin_q <= 1'b1;
        else len_q <= len_q + 64'd8;
      end
      if (state_q == ST_LEN && blk_done) len_done_q <= 1'b1;
      if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
      if (state_q == ST_FOLD) begin
        h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
      end
      if (state_q == ST_EMIT && out_ready_i) begin
        oidx_q <= oidx_q + 2'd1;
        if (oidx_q == 2'd3) begin
          h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
          len_q <= '0; fin_q <= 1'b0; len_done_q <= 1'b0;
        end
      end
    end
  end

endmodule

@@ design/md5_message_digest.sv @@
// ----------------------------------------------------------------------------
// md5_message_digest
// md5 digest over a byte stream, front queue and round core
// ----------------------------------------------------------------------------
// in channel: one word per handshake, action absorb carries a data byte,
// action finish closes the message. out channel: four digest words, index 0
// to 3, last_word set on the fourth.
// the core takes a byte from the queue whenever it is idle; the 64th byte of a
// block holds the core through the round and fold states of the single round unit.
// finish pads the message and appends its bit length, filling one or two blocks,
// then presents the four words, one per cycle while out_ready_i is high.
// a two-entry queue lets bytes be taken while the core is busy or the
// receiver stalls; in_ready_o drops only when the queue is full.
// reset loads the initial chaining value, clears length and byte position.
// ----------------------------------------------------------------------------
module md5_message_digest import md5_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  md5_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output md5_out_t out_data_o
);

  logic    full, empty, pop;
  md5_in_t qword;

  assign in_ready_o = !full;

  md5_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(in_valid_i), .push_data_i(in_data_i), .full_o(full),
    .pop_i(pop), .pop_data_o(qword), .empty_o(empty)
  );

  md5_core u_core (
    .clk_i, .rst_ni,
    .empty_i(empty), .word_i(qword), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

`ifndef ASSERT_OFF
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 2'd3)))
    else $error("last_word mismatch");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed under stall");
  a_no_pop_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !pop)
    else $error("queue popped during output");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the md5 byte-stream digest block
// ----------------------------------------------------------------------------
// messages of random length and content are streamed in byte by byte and
// closed by a finish word. a scoreboard computes the digest of each message
// and checks the four output words in order, under varied idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import md5_pkg::*;

  class md5_scoreboard;
    logic [31:0] chain[4];
    logic [31:0] blk[16];
    logic [5:0]  pos;
    logic [63:0] nbits;
    md5_out_t    pending[$];
    int          errors;
    int          digests;

    function new();
      errors = 0;
      digests = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
      pos = '0;
      nbits = '0;
    endfunction

    function logic [31:0] kconst(int r);
      logic [31:0] t[64];
      t = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
            32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
            32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
            32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
            32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
            32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
            32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
            32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
            32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return t[r];
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, s, h;
      int          g, sh, st;
      int          rots[16];
      rots = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int r = 0; r < 64; r++) begin
        st = r / 16;
        case (st)
          0: begin f = (b & c) | (~b & d); g = r; end
          1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
          2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
          default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
        endcase
        sh = rots[st * 4 + r % 4];
        s = a + f + kconst(r) + blk[g];
        s = (s << sh) | (s >> (32 - sh));
        h = d; d = c; c = b; b = b + s; a = h;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function void pack_byte(logic [7:0] v);
      if (pos[1:0] == 2'd0) blk[pos[5:2]] = {24'd0, v};
      else blk[pos[5:2]][8 * pos[1:0] +: 8] = v;
      pos = pos + 6'd1;
      if (pos == 6'd0) compress();
    endfunction

    function void note_input(md5_in_t w);
      logic [63:0] total;
      md5_out_t    o;
      if (w.action == ACT_ABSORB) begin
        pack_byte(w.data_byte);
        nbits = nbits + 64'd8;
      end else begin
        total = nbits;
        pack_byte(8'h80);
        while (pos != 6'd56) pack_byte(8'h00);
        for (int k = 0; k < 8; k++) pack_byte(total[8 * k +: 8]);
        for (int k = 0; k < 4; k++) begin
          o.digest_word = chain[k];
          o.word_index = 2'(k);
          o.last_word = (k == 3);
          pending.push_back(o);
        end
        restart();
      end
    endfunction

    function void check_result(md5_out_t got);
      md5_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected digest word %h", got.digest_word);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.digest_word !== e.digest_word) begin
        $error("digest_word exp %h got %h", e.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== e.word_index) begin
        $error("word_index exp %0d got %0d", e.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== e.last_word) begin
        $error("last_word exp %0d got %0d", e.last_word, got.last_word);
        errors++;
      end
      if (e.last_word) digests++;
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  md5_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  md5_out_t out_data_o;

  md5_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  int words_sent = 0;

  md5_message_digest u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: ready pattern and result checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_word(action_e act, logic [7:0] b);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{action: act, data_byte: b};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(in_data_i);
    words_sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_word(ACT_ABSORB, 8'($urandom));
    send_word(ACT_FINISH, 8'($urandom));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(54, 57);
    if (r < 25) return $urandom_range(62, 66);
    if (r < 30) return $urandom_range(118, 130);
    return $urandom_range(0, 40);
  endfunction

  initial begin
    int wait_cycles;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty, byte extremes, boundary lengths
    send_word(ACT_FINISH, 8'hff);
    send_word(ACT_ABSORB, 8'h00);
    send_word(ACT_ABSORB, 8'hff);
    send_word(ACT_FINISH, 8'h00);
    send_message(55);
    send_message(56);
    send_message(64);
    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 74; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 74; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      if (ph == 0) hold_cycles = 600;
      while (words_sent < 180 + 75 * (ph + 1)) send_message(pick_len());
    end
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (300) @(posedge clk_i);
    $display("%0d words sent, %0d digests checked across four idling phases",
             words_sent, sb.digests);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("md5_message_digest regression: pass");
    else
      $display("md5_message_digest regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("md5_message_digest regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
design/md5_pkg.sv
design/md5_queue.sv
design/md5_core.sv
design/md5_message_digest.sv
tb/tb_top.sv
